// ----- hw/rtl/cpa_pkg.sv -----
package cpa_pkg;

	// Region geometry.
	localparam int REGION_PAGES    = 1024;
	localparam int PAGE_BYTES_LOG2 = 12;

	// Data widths.
	localparam int ADDR_W = 32;
	localparam int EXT_W  = 40;

	// The page map is kept in words of WORD_BITS pages.
	localparam int WORD_BITS = 32;
	localparam int LANE_W    = $clog2(WORD_BITS);
	localparam int NUM_WORDS = (REGION_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PG_W      = WIDX_W + LANE_W;
	localparam int NP_W      = $clog2(REGION_PAGES + 1);
	localparam int LPG_W     = ADDR_W + 1 - PAGE_BYTES_LOG2;

	localparam logic [ADDR_W:0] PG_OFS_MASK =
		(ADDR_W + 1)'((64'd1 << PAGE_BYTES_LOG2) - 64'd1);
	localparam logic [EXT_W-1:0] REGION_BYTES =
		EXT_W'(64'(REGION_PAGES) << PAGE_BYTES_LOG2);

	// Request types.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_NOMEM = 2'd2
	} status_t;

	// What the request check decides.
	typedef enum logic [2:0] {
		ACT_INVAL,
		ACT_NOMEM,
		ACT_TEST,
		ACT_SCAN,
		ACT_CLEAR
	} act_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_TEST,
		S_SET,
		S_CLEAR,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic scan_step;
		logic test_step;
		logic set_step;
		logic clear_step;
		logic publish;
	} cmd_t;

	typedef struct packed {
		act_t action;
		logic scan_hit;
		logic scan_last;
		logic range_last;
		logic conflict;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/cpa_controller.sv -----
module cpa_controller import cpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t state_q, state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_CHECK;
			end
			S_CHECK: begin
				case (sts.action)
					ACT_TEST:  state_nxt = S_TEST;
					ACT_SCAN:  state_nxt = S_SCAN;
					ACT_CLEAR: state_nxt = S_CLEAR;
					default:   state_nxt = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_hit) state_nxt = S_SET;
				else if (sts.scan_last) state_nxt = S_DONE;
			end
			S_TEST: begin
				if (sts.conflict) state_nxt = S_DONE;
				else if (sts.range_last) state_nxt = S_SET;
			end
			S_SET, S_CLEAR: begin
				if (sts.range_last) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready       = (state_q == S_IDLE);
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.check      = (state_q == S_CHECK);
		cmd.scan_step  = (state_q == S_SCAN);
		cmd.test_step  = (state_q == S_TEST);
		cmd.set_step   = (state_q == S_SET);
		cmd.clear_step = (state_q == S_CLEAR);
		cmd.publish    = (state_q == S_DONE) && sts.out_free;
	end

endmodule

// ----- hw/rtl/cpa_datapath.sv -----
module cpa_datapath import cpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  logic              req_type,
	input  logic              fixed_place,
	input  logic [ADDR_W-1:0] req_address,
	input  logic [ADDR_W-1:0] length_bytes,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] result_address
);

	logic [ADDR_W-1:0]    base_q;
	logic                 type_q;
	logic                 fixed_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    len_q;
	logic [WORD_BITS-1:0] map_q [NUM_WORDS];
	logic [WIDX_W-1:0]    w_q;
	logic [NP_W-1:0]      run_q;
	logic [NP_W-1:0]      np_q;
	logic [PG_W-1:0]      first_q;
	logic [PG_W-1:0]      last_q;
	status_t              st_q;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [ADDR_W-1:0]    raddr_q;

	// Request check signals.
	logic [ADDR_W:0]    len_round;
	logic [LPG_W-1:0]   np_full;
	logic [EXT_W-1:0]   size_x;
	logic [EXT_W-1:0]   addr_x;
	logic [EXT_W-1:0]   base_x;
	logic [EXT_W-1:0]   off_x;
	logic               addr_ok;
	logic [PG_W-1:0]    start_pg;
	logic [NP_W-1:0]    np_eff;
	logic [PG_W-1:0]    last_pg;
	act_t               action;

	// Map word signals.
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] rng_mask;
	logic [WORD_BITS-1:0] hit;
	logic [NP_W:0]        run_bit [WORD_BITS];
	logic [LANE_W-1:0]    hit_idx;
	logic [PG_W-1:0]      end_pg;
	logic [PG_W-1:0]      found_pg;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= req_type;
			fixed_q <= fixed_place;
			addr_q  <= req_address;
			len_q   <= length_bytes;
		end
	end

	// Length rounding, address range and alignment checks.
	always_comb begin
		len_round = {1'b0, len_q} + PG_OFS_MASK;
		np_full   = len_round[ADDR_W:PAGE_BYTES_LOG2];
		if (type_q == REQ_FREE) size_x = EXT_W'(len_q);
		else size_x = EXT_W'(np_full) << PAGE_BYTES_LOG2;
		addr_x  = EXT_W'(addr_q);
		base_x  = EXT_W'(base_q);
		off_x   = addr_x - base_x;
		addr_ok = (addr_x >= base_x) && (size_x <= REGION_BYTES) &&
			(off_x <= REGION_BYTES - size_x) && (addr_q[PAGE_BYTES_LOG2-1:0] == '0);
		start_pg = PG_W'(off_x >> PAGE_BYTES_LOG2);
		np_eff   = NP_W'(np_full);
		last_pg  = start_pg + PG_W'(np_eff) - PG_W'(1);

		if (len_q == '0) begin
			action = ACT_INVAL;
		end else if (type_q == REQ_ALLOC) begin
			if (np_full > LPG_W'(REGION_PAGES)) action = ACT_NOMEM;
			else if (!fixed_q) action = ACT_SCAN;
			else if (!addr_ok) action = ACT_INVAL;
			else action = ACT_TEST;
		end else begin
			if ((addr_q == '0) || !addr_ok) action = ACT_INVAL;
			else action = ACT_CLEAR;
		end
	end

	// Current map word, its free pages and the pages of the active range.
	always_comb begin
		logic [PG_W-1:0] pg;
		word = map_q[w_q];
		for (int i = 0; i < WORD_BITS; i++) begin
			pg           = {w_q, LANE_W'(i)};
			free_bits[i] = !word[i] && (32'(pg) < 32'(REGION_PAGES));
			rng_mask[i]  = (pg >= first_q) && (pg <= last_q);
		end
	end

	// Free run length ending at each page of the word, carried in from below.
	always_comb begin
		logic              seen;
		logic [LANE_W-1:0] lu;
		for (int i = 0; i < WORD_BITS; i++) begin
			seen = 1'b0;
			lu   = '0;
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j <= i && !free_bits[j]) begin
					seen = 1'b1;
					lu   = LANE_W'(j);
				end
			end
			if (seen) run_bit[i] = (NP_W + 1)'(LANE_W'(i) - lu);
			else run_bit[i] = {1'b0, run_q} + (NP_W + 1)'(i + 1);
			hit[i] = (run_bit[i] >= {1'b0, np_q});
		end
		hit_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit[i]) hit_idx = LANE_W'(i);
		end
		end_pg   = {w_q, hit_idx};
		found_pg = end_pg - PG_W'(np_q) + PG_W'(1);
	end

	// Status to the controller.
	always_comb begin
		sts.action     = action;
		sts.scan_hit   = |hit;
		sts.scan_last  = (32'(w_q) == 32'(NUM_WORDS - 1));
		sts.range_last = (w_q == last_q[PG_W-1:LANE_W]);
		sts.conflict   = |(word & rng_mask);
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Map walk, run tracking and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_WORDS; k++) map_q[k] <= '0;
		end else if (cmd.set_step) begin
			map_q[w_q] <= word | rng_mask;
		end else if (cmd.clear_step) begin
			map_q[w_q] <= word & ~rng_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			first_q <= start_pg;
			last_q  <= last_pg;
			np_q    <= np_eff;
			run_q   <= '0;
			if (action == ACT_SCAN) w_q <= '0;
			else w_q <= start_pg[PG_W-1:LANE_W];
			case (action)
				ACT_INVAL: st_q <= ST_INVAL;
				ACT_NOMEM: st_q <= ST_NOMEM;
				default:   st_q <= ST_OK;
			endcase
		end else if (cmd.scan_step) begin
			if (|hit) begin
				first_q <= found_pg;
				last_q  <= end_pg;
				w_q     <= found_pg[PG_W-1:LANE_W];
			end else begin
				run_q <= NP_W'(run_bit[WORD_BITS-1]);
				w_q   <= w_q + WIDX_W'(1);
				if (sts.scan_last) st_q <= ST_NOMEM;
			end
		end else if (cmd.test_step) begin
			if (sts.conflict) st_q <= ST_NOMEM;
			else if (sts.range_last) w_q <= first_q[PG_W-1:LANE_W];
			else w_q <= w_q + WIDX_W'(1);
		end else if (cmd.set_step || cmd.clear_step) begin
			w_q <= w_q + WIDX_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			status_q <= st_q;
			if (st_q == ST_OK && type_q == REQ_ALLOC)
				raddr_q <= base_q + (ADDR_W'(first_q) << PAGE_BYTES_LOG2);
			else
				raddr_q <= '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = raddr_q;

endmodule

// ----- hw/rtl/contiguous_page_allocator_unit.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    req_type, fixed_place, req_address, length_bytes
// out       out_valid / out_ready  status, result_address
// cfg       cfg_wr_en              cfg_wr_data (region_base)
//
// One request at a time: the request is accepted while idle and checked, then any map
// words it needs are walked in turn, then the output register is loaded once free.
// A first-fit search walks the map words from the lowest; marking or clearing a
// run steps through each map word it touches.
// The page map is 32 words of 32 flip-flops, cleared to free at reset.
// A finished result waits in the output register while the next request runs.
module contiguous_page_allocator_unit import cpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic              fixed_place,
	input  logic [ADDR_W-1:0] req_address,
	input  logic [ADDR_W-1:0] length_bytes,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] result_address
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	cpa_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Page map and request datapath.
	cpa_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.req_type       (req_type),
		.fixed_place    (fixed_place),
		.req_address    (req_address),
		.length_bytes   (length_bytes),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.result_address (result_address)
	);

endmodule

// ----- hw/rtl/cpa_checker.sv -----
module cpa_checker import cpa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [ADDR_W-1:0] result_address
);

	// A request is worked on alone: no new transaction right after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_INVAL || status == ST_NOMEM))
		else $error("undefined status code");

	// A failed request returns address zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_address == '0)
		else $error("failed request with nonzero address");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_address))
		else $error("stalled result changed");

endmodule

bind contiguous_page_allocator_unit cpa_checker u_cpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.result_address (result_address)
);

// ----- sim/tb_top.sv -----
module tb_top;
	import cpa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAGE_BYTES = 1 << PAGE_BYTES_LOG2;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		status_t status;
		logic [ADDR_W-1:0] address;
	} outcome_t;

	// A run of pages that the predictor marked used on a successful allocate.
	typedef struct {
		int first_page;
		int num_pages;
	} page_run_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [ADDR_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic fixed_place;
	logic [ADDR_W-1:0] req_address;
	logic [ADDR_W-1:0] length_bytes;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [ADDR_W-1:0] result_address;

	// Predictor state: page map and region base.
	bit page_map[REGION_PAGES];
	logic [ADDR_W-1:0] model_base;

	outcome_t pending_outcomes[$];
	page_run_t live_runs[$];
	int error_count;
	int cycle_count;
	bit steady_flow;

	contiguous_page_allocator_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.fixed_place(fixed_place),
		.req_address(req_address),
		.length_bytes(length_bytes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_address(result_address)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Checks whether a byte range starts page-aligned and lies inside the region.
	function automatic bit range_valid(input longint unsigned addr, input longint unsigned size);
		longint unsigned base;
		longint unsigned rb;
		base = model_base;
		rb = longint'(REGION_PAGES) << PAGE_BYTES_LOG2;
		if (addr < base || size > rb || addr - base > rb - size)
			return 1'b0;
		return (addr & (PAGE_BYTES - 1)) == 0;
	endfunction

	function automatic longint unsigned bytes_to_pages(input longint unsigned len);
		return (len + PAGE_BYTES - 1) >> PAGE_BYTES_LOG2;
	endfunction

	// Computes the outcome of one request and updates the page map.
	function automatic outcome_t allocate_or_free(input logic rt, input logic fx,
			input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len);
		outcome_t res;
		longint unsigned np;
		longint unsigned first;
		longint unsigned last;
		longint unsigned run;
		bit found;
		page_run_t pr;
		res.status = ST_OK;
		res.address = '0;
		found = 1'b0;
		first = 0;
		if (len == 0) begin
			res.status = ST_INVAL;
		end else if (rt == REQ_ALLOC) begin
			np = bytes_to_pages(len);
			if (np > REGION_PAGES) begin
				res.status = ST_NOMEM;
			end else if (fx) begin
				if (!range_valid(addr, np << PAGE_BYTES_LOG2)) begin
					res.status = ST_INVAL;
				end else begin
					first = (longint'(addr) - longint'(model_base)) >> PAGE_BYTES_LOG2;
					found = 1'b1;
					for (longint unsigned k = 0; k < np; k++) begin
						if (first + k >= REGION_PAGES || page_map[first + k]) begin
							found = 1'b0;
							break;
						end
					end
					if (!found)
						res.status = ST_NOMEM;
				end
			end else begin
				run = 0;
				for (int p = 0; p < REGION_PAGES; p++) begin
					if (page_map[p]) begin
						run = 0;
					end else begin
						if (run == 0)
							first = p;
						run++;
						if (run == np) begin
							found = 1'b1;
							break;
						end
					end
				end
				if (!found)
					res.status = ST_NOMEM;
			end
			if (found) begin
				for (longint unsigned k = 0; k < np; k++)
					page_map[first + k] = 1'b1;
				res.address = model_base + ADDR_W'(first << PAGE_BYTES_LOG2);
				pr.first_page = int'(first);
				pr.num_pages = int'(np);
				live_runs.push_back(pr);
			end
		end else begin
			if (addr == 0 || !range_valid(addr, len)) begin
				res.status = ST_INVAL;
			end else begin
				first = (longint'(addr) - longint'(model_base)) >> PAGE_BYTES_LOG2;
				last = first + bytes_to_pages(len);
				if (last > REGION_PAGES)
					last = REGION_PAGES;
				for (longint unsigned p = first; p < last; p++)
					page_map[p] = 1'b0;
			end
		end
		return res;
	endfunction

	// Sends one request after a random gap and records its expected outcome.
	task automatic send_request(input logic rt, input logic fx,
			input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = rt;
		fixed_place = fx;
		req_address = addr;
		length_bytes = len;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		pending_outcomes.push_back(allocate_or_free(rt, fx, addr, len));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_region_base(input logic [ADDR_W-1:0] value);
		wait_idle();
		cfg_wr_data = value;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		model_base = value;
	endtask

	// Directed cases at region base zero.
	task automatic test_directed();
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h0);
		send_request(REQ_FREE, 1'b0, 32'h0, 32'h1000);
		send_request(REQ_FREE, 1'b0, 32'h1000, 32'h0);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h1);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h1001);
		send_request(REQ_ALLOC, 1'b1, 32'h10000, 32'h1000);
		send_request(REQ_ALLOC, 1'b1, 32'h10000, 32'h800);
		send_request(REQ_ALLOC, 1'b1, 32'h10001, 32'h1000);
		send_request(REQ_ALLOC, 1'b1, 32'h400000, 32'h1000);
		send_request(REQ_ALLOC, 1'b1, 32'h3FF000, 32'h2000);
		send_request(REQ_ALLOC, 1'b1, 32'hFFFFF000, 32'hFFFFFFFF);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'hFFFFFFFF);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h400000);
		send_request(REQ_FREE, 1'b1, 32'h1000, 32'h1000);
		send_request(REQ_FREE, 1'b0, 32'h1800, 32'h1000);
		send_request(REQ_FREE, 1'b0, 32'h20000, 32'h1000);
		send_request(REQ_FREE, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_request(REQ_FREE, 1'b0, 32'h1000, 32'h3FF000);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h3FF000);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h1);
		send_request(REQ_FREE, 1'b0, 32'h3FD000, 32'h3000);
		send_request(REQ_ALLOC, 1'b0, 32'h0, 32'h4000);
		send_request(REQ_ALLOC, 1'b1, 32'h3FD000, 32'h3000);
		send_request(REQ_FREE, 1'b0, 32'h1000, 32'hFFFFFFFF);
		send_request(REQ_FREE, 1'b0, 32'h1000, 32'h3FF000);
	endtask

	// Mostly well-formed allocate and free traffic with some noise.
	task automatic test_random(input int count);
		int pick;
		int pages;
		int idx;
		logic fx;
		logic [ADDR_W-1:0] len;
		page_run_t pr;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				steady_flow = ($urandom_range(0, 3) == 0);
			// Let the block drain completely once per phase.
			if (n == count / 2)
				wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom, $urandom);
			end else if (pick < 14) begin
				send_request(REQ_FREE, 1'b0, model_base + PAGE_BYTES,
					(REGION_PAGES - 1) * PAGE_BYTES);
			end else if (pick < 55 || live_runs.size() == 0) begin
				pages = ($urandom_range(0, 30) == 0) ? $urandom_range(1, REGION_PAGES + 1)
					: $urandom_range(1, 16);
				len = pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1);
				fx = ($urandom_range(0, 3) == 0);
				send_request(REQ_ALLOC, fx,
					model_base + $urandom_range(0, REGION_PAGES - 1) * PAGE_BYTES, len);
			end else begin
				idx = $urandom_range(0, live_runs.size() - 1);
				pr = live_runs[idx];
				live_runs.delete(idx);
				len = pr.num_pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1);
				send_request(REQ_FREE, 1'($urandom_range(0, 1)),
					model_base + pr.first_page * PAGE_BYTES, len);
			end
		end
		steady_flow = 1'b0;
	endtask

	// Result checker with random back-pressure.
	initial begin
		outcome_t exp;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			if (pending_outcomes.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected transaction: status %0d address %h",
						status, result_address);
			end else begin
				exp = pending_outcomes.pop_front();
				if (status !== exp.status || result_address !== exp.address) begin
					error_count++;
					if (error_count <= 10)
						$display("Mismatch: expected status %0d address %h, got %0d %h",
							exp.status, exp.address, status, result_address);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		error_count = 0;
		steady_flow = 1'b0;
		model_base = '0;
		foreach (page_map[p])
			page_map[p] = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		req_type = REQ_ALLOC;
		fixed_place = 1'b0;
		req_address = '0;
		length_bytes = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(390);
		set_region_base(32'hFFFFF000);
		test_random(390);
		set_region_base(32'h00001234);
		test_random(390);
		set_region_base(32'hFFFFFFFF);
		test_random(390);
		set_region_base($urandom & ~(PAGE_BYTES - 1) & 32'h7FFFFFFF);
		test_random(390);
		set_region_base(32'h0);
		test_random(100);

		wait_idle();
		if (error_count == 0 && pending_outcomes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
